// ===== src/pca_pkg.sv =====
`timescale 1ns / 1ps
package pca_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int COORD_W      = 16;
    localparam int CROSS_W      = 41;
    localparam int WSUM_W       = 58;
    localparam int PSUM_W       = 25;
    localparam int AREA_W       = 39;
    localparam int EPS_W        = 8;
    localparam int DEN_W        = CROSS_W + 2;
    localparam int QBITS        = 18;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] REG_EPSILON = 3'd0;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic                      last;
        logic                      first;
        logic                      keep;
    } pca_item_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_M0,
        S_M1,
        S_M2,
        S_M3,
        S_FIN,
        S_DXS,
        S_DXW,
        S_DYS,
        S_DYW,
        S_OUT
    } pca_state_t;

    typedef struct packed {
        logic pop;
        logic div_start;
        logic out_load;
    } pca_ctrl_t;

endpackage

// ===== src/pca_front.sv =====
`timescale 1ns / 1ps
module pca_front
    import pca_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic signed [COORD_W-1:0] in_x,
    input  logic signed [COORD_W-1:0] in_y,
    input  logic                      in_last,
    output logic                      q_valid,
    output pca_item_t                 q_item,
    input  logic                      q_pop
);

    pca_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]     fill_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                push;
    pca_item_t           new_item;

    assign s_tready = (fill_reg != QPTR_W'(0) + (QPTR_W+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (fill_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];

    // classify against the running count of the current polygon
    always_comb begin
        new_item.x     = in_x;
        new_item.y     = in_y;
        new_item.last  = in_last;
        new_item.first = (count_reg == '0);
        new_item.keep  = (count_reg < CNT_W'(MAX_VERTICES));
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
                if (in_last) begin
                    count_reg <= '0;
                end else if (new_item.keep) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !q_pop) begin
                fill_reg <= fill_reg + (QPTR_W+1)'(1);
            end else if (!push && q_pop) begin
                fill_reg <= fill_reg - (QPTR_W+1)'(1);
            end
        end
    end

endmodule

// ===== src/pca_div.sv =====
`timescale 1ns / 1ps
module pca_div
    import pca_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic signed [WSUM_W-1:0]  num,
    input  logic signed [DEN_W-1:0]   den,
    output logic                      done,
    output logic signed [COORD_W-1:0] quot
);

    localparam int REM_W = WSUM_W + QBITS - 1 + 1;

    logic                busy_reg, done_reg, neg_reg;
    logic [4:0]          step_reg;
    logic [REM_W-1:0]    rem_reg, dsh_reg;
    logic [QBITS-1:0]    q_reg;
    logic [WSUM_W-1:0]   num_mag;
    logic [DEN_W-1:0]    den_mag;
    logic                fits;

    assign num_mag = num[WSUM_W-1] ? WSUM_W'(-num) : WSUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign fits    = (rem_reg >= dsh_reg);
    assign done    = done_reg;

    // truncated quotient, then clamp to the 16-bit signed range
    always_comb begin
        if (neg_reg) begin
            if (q_reg > QBITS'(32768)) begin
                quot = 16'sh8000;
            end else begin
                quot = COORD_W'(-q_reg);
            end
        end else begin
            if (q_reg > QBITS'(32767)) begin
                quot = 16'sh7FFF;
            end else begin
                quot = COORD_W'(q_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= REM_W'(num_mag);
            dsh_reg <= {den_mag, (QBITS-1)'(0)} << 0;
            q_reg   <= '0;
            neg_reg <= num[WSUM_W-1] ^ den[DEN_W-1];
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QBITS-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 5'(QBITS - 1);
            end else if (busy_reg) begin
                if (step_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg - 5'd1;
                end
            end
        end
    end

endmodule

// ===== src/pca_back.sv =====
`timescale 1ns / 1ps
module pca_back
    import pca_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [EPS_W-1:0]          epsilon,
    input  logic                      q_valid,
    input  pca_item_t                 q_item,
    output logic                      q_pop,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic signed [COORD_W-1:0] out_cx,
    output logic signed [COORD_W-1:0] out_cy,
    output logic [AREA_W-1:0]         out_area,
    output logic                      out_degen
);

    pca_state_t state_reg, state_next;
    pca_ctrl_t  ctrl;

    logic signed [COORD_W-1:0] first_x_reg, first_y_reg, prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0] e_x0_reg, e_y0_reg, e_x1_reg, e_y1_reg;
    logic signed [CROSS_W-1:0] cross_reg;
    logic signed [WSUM_W-1:0]  wx_reg, wy_reg;
    logic signed [PSUM_W-1:0]  px_reg, py_reg;
    logic [CNT_W-1:0]          count_reg;
    logic                      last_reg, closing_reg, pend_reg;
    logic signed [31:0]        p0_reg;
    logic signed [32:0]        c_reg;
    logic signed [49:0]        prod_reg;
    logic [AREA_W-1:0]         area_reg;
    logic                      degen_reg;
    logic signed [COORD_W-1:0] cx_reg;

    logic signed [16:0]        mul_a;
    logic signed [32:0]        mul_b;
    logic signed [49:0]        mul_p;
    logic [CROSS_W-1:0]        abs_cross;
    logic signed [DEN_W-1:0]   den3;
    logic signed [WSUM_W-1:0]  div_num;
    logic signed [DEN_W-1:0]   div_den;
    logic                      div_done;
    logic signed [COORD_W-1:0] div_q;
    logic                      out_free;

    assign q_pop    = ctrl.pop;
    assign out_free = !m_tvalid || m_tready;
    assign abs_cross = cross_reg[CROSS_W-1] ? CROSS_W'(-cross_reg) : CROSS_W'(cross_reg);
    assign den3 = (DEN_W'(cross_reg) <<< 1) + DEN_W'(cross_reg);

    // one shared 17 x 33 multiplier, four products per edge
    always_comb begin
        case (state_reg)
            S_M0: begin
                mul_a = 17'(e_x0_reg);
                mul_b = 33'(e_y1_reg);
            end
            S_M1: begin
                mul_a = 17'(e_x1_reg);
                mul_b = 33'(e_y0_reg);
            end
            S_M2: begin
                mul_a = 17'(e_x0_reg) + 17'(e_x1_reg);
                mul_b = c_reg;
            end
            S_M3: begin
                mul_a = 17'(e_y0_reg) + 17'(e_y1_reg);
                mul_b = c_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_comb begin
        if (degen_reg) begin
            div_num = WSUM_W'(state_reg == S_DYS ? py_reg : px_reg);
            div_den = DEN_W'(count_reg);
        end else begin
            div_num = (state_reg == S_DYS) ? wy_reg : wx_reg;
            div_den = den3;
        end
    end

    pca_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_q)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_item.keep && !q_item.first) begin
                        state_next = S_M0;
                    end else if (q_item.last) begin
                        state_next = S_M0;
                    end
                end
            end
            S_M0: state_next = S_M1;
            S_M1: state_next = S_M2;
            S_M2: state_next = S_M3;
            S_M3: begin
                if (closing_reg) begin
                    state_next = S_FIN;
                end else if (last_reg) begin
                    state_next = S_M0;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_FIN: state_next = S_DXS;
            S_DXS: state_next = S_DXW;
            S_DXW: begin
                if (div_done) begin
                    state_next = S_DYS;
                end
            end
            S_DYS: state_next = S_DYW;
            S_DYW: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl.pop       = (state_reg == S_IDLE) && q_valid;
        ctrl.div_start = (state_reg == S_DXS) || (state_reg == S_DYS);
        ctrl.out_load  = (state_reg == S_OUT) && out_free;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_x_reg <= '0;
            first_y_reg <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            cross_reg   <= '0;
            wx_reg      <= '0;
            wy_reg      <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            count_reg   <= '0;
            last_reg    <= 1'b0;
            closing_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            if (pend_reg) begin
                wy_reg   <= wy_reg + WSUM_W'(prod_reg);
                pend_reg <= 1'b0;
            end
            if (ctrl.pop) begin
                last_reg <= q_item.last;
                if (q_item.keep && q_item.first) begin
                    first_x_reg <= q_item.x;
                    first_y_reg <= q_item.y;
                    prev_x_reg  <= q_item.x;
                    prev_y_reg  <= q_item.y;
                    px_reg      <= PSUM_W'(q_item.x);
                    py_reg      <= PSUM_W'(q_item.y);
                    count_reg   <= CNT_W'(1);
                    e_x0_reg    <= q_item.x;
                    e_y0_reg    <= q_item.y;
                    e_x1_reg    <= q_item.x;
                    e_y1_reg    <= q_item.y;
                    closing_reg <= 1'b1;
                end else if (q_item.keep) begin
                    prev_x_reg  <= q_item.x;
                    prev_y_reg  <= q_item.y;
                    px_reg      <= px_reg + PSUM_W'(q_item.x);
                    py_reg      <= py_reg + PSUM_W'(q_item.y);
                    count_reg   <= count_reg + CNT_W'(1);
                    e_x0_reg    <= prev_x_reg;
                    e_y0_reg    <= prev_y_reg;
                    e_x1_reg    <= q_item.x;
                    e_y1_reg    <= q_item.y;
                    closing_reg <= 1'b0;
                end else begin
                    // dropped vertex: a final one still closes the ring
                    e_x0_reg    <= prev_x_reg;
                    e_y0_reg    <= prev_y_reg;
                    e_x1_reg    <= first_x_reg;
                    e_y1_reg    <= first_y_reg;
                    closing_reg <= 1'b1;
                end
            end
            case (state_reg)
                S_M0: p0_reg <= 32'(mul_p);
                S_M1: c_reg  <= 33'(p0_reg) - 33'(mul_p);
                S_M2: prod_reg <= mul_p;
                S_M3: begin
                    prod_reg  <= mul_p;
                    wx_reg    <= wx_reg + WSUM_W'(prod_reg);
                    cross_reg <= cross_reg + CROSS_W'(c_reg);
                    pend_reg  <= 1'b1;
                    if (!closing_reg && last_reg) begin
                        e_x0_reg    <= e_x1_reg;
                        e_y0_reg    <= e_y1_reg;
                        e_x1_reg    <= first_x_reg;
                        e_y1_reg    <= first_y_reg;
                        closing_reg <= 1'b1;
                    end
                end
                S_FIN: begin
                    area_reg  <= abs_cross[CROSS_W-1:1] > (CROSS_W-1)'({AREA_W{1'b1}})
                               ? {AREA_W{1'b1}} : AREA_W'(abs_cross[CROSS_W-1:1]);
                    degen_reg <= (abs_cross <= CROSS_W'(epsilon));
                end
                S_DXW: begin
                    if (div_done) begin
                        cx_reg <= div_q;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        cross_reg <= '0;
                        wx_reg    <= '0;
                        wy_reg    <= '0;
                        count_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // result register, frees the back end while the transaction waits
    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_cx    <= cx_reg;
            out_cy    <= div_q;
            out_area  <= area_reg;
            out_degen <= degen_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid <= 1'b0;
        end else if (ctrl.out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

endmodule

// ===== src/polygon_centroid_area.sv =====
`timescale 1ns / 1ps
// channel   dir  tdata (low bit first)                 tuser / tlast
// s_        in   vertex_x[15:0], vertex_y[31:16]        tlast = last_vertex
// m_        out  centroid_x[15:0], centroid_y[31:16],   tuser = degenerate
//                area[70:32], zero pad [71]
// apb       in   0x0: degenerate_epsilon[7:0]
//
// A vertex holds the back end for a pop and 4 products through the
// shared multiplier (the first vertex of a polygon only for the pop).
// The last vertex adds the closing edge (4 more products), one area step and
// two 18-step divisions before the registered result (its own edge is skipped
// when it is the only kept vertex or is dropped).
// A 4-entry input queue keeps taking vertices, until it is full, while the back
// end works or the result transaction stalls. Reset is synchronous and clears all accumulators.
module polygon_centroid_area
    import pca_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // vertex_x, vertex_y
    input  logic        s_tlast,   // last_vertex
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // centroid_x, centroid_y, area, pad
    output logic        m_tuser,   // degenerate
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [EPS_W-1:0]          eps_reg;
    logic                      q_valid, q_pop;
    pca_item_t                 q_item;
    logic signed [COORD_W-1:0] cx, cy;
    logic [AREA_W-1:0]         area;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPSILON[0]) ? 32'(eps_reg) : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eps_reg <= '0;
        end else if (psel && penable && pwrite && paddr[2] == REG_EPSILON[0]) begin
            eps_reg <= pwdata[EPS_W-1:0];
        end
    end

    pca_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_x     (s_tdata[15:0]),
        .in_y     (s_tdata[31:16]),
        .in_last  (s_tlast),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    pca_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .epsilon   (eps_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .out_cx    (cx),
        .out_cy    (cy),
        .out_area  (area),
        .out_degen (m_tuser)
    );

    assign m_tdata = {1'b0, area, cy, cx};

endmodule
